// ===== hw/rtl/keypad_code_lock_fsm_defines.svh =====
// Assertion macros for the keypad code lock checker.
// Both expect clk and rst_n in scope at the place of use.
`ifndef KEYPAD_CODE_LOCK_FSM_DEFINES_SVH
`define KEYPAD_CODE_LOCK_FSM_DEFINES_SVH

// Same-cycle implication.
`define KCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kcl_pkg.sv =====
package kcl_pkg;

    localparam int KEY_W    = 4;
    localparam int HOLD_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_W    = 56;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_HOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_HOLD = 1'b1;

    localparam logic [HOLD_W-1:0] ERROR_HOLD_RESET  = 12'd3000;
    localparam logic [HOLD_W-1:0] UPDATE_HOLD_RESET = 12'd2000;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR       = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH       = 4'd11;

    // Item kinds.
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Mode codes as shown on the result stream.
    localparam logic [2:0] MODE_LOCKED   = 3'd0;
    localparam logic [2:0] MODE_UNLOCKED = 3'd1;
    localparam logic [2:0] MODE_ERROR    = 3'd2;
    localparam logic [2:0] MODE_SETPIN   = 3'd3;
    localparam logic [2:0] MODE_UPDATED  = 3'd4;

    typedef enum logic [4:0] {
        ST_LOCKED   = 5'b00001,
        ST_UNLOCKED = 5'b00010,
        ST_ERROR    = 5'b00100,
        ST_SETPIN   = 5'b01000,
        ST_UPDATED  = 5'b10000
    } mode_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            ST_LOCKED:   c = MODE_LOCKED;
            ST_UNLOCKED: c = MODE_UNLOCKED;
            ST_ERROR:    c = MODE_ERROR;
            ST_SETPIN:   c = MODE_SETPIN;
            ST_UPDATED:  c = MODE_UPDATED;
            default:     c = MODE_LOCKED;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/keypad_code_lock_fsm.sv =====
// Keypad code lock controller.
//
// Input stream (s_*): one request per key press or per millisecond tick.
//   s_tuser is the kind (0 key press, 1 tick), s_tdata[3:0] the key code
//   (0-9 digits, 10 star, 11 hash); the key is ignored on ticks.
// Result stream (m_*): exactly one result per request, showing the lock state
//   after that request: mode, lock drive, entry progress, a pin write strobe
//   and the stored PIN.
// Configuration port: cfg_we writes cfg_data to register cfg_index
//   (0 error hold ticks, 1 PIN-updated hold ticks); write only while idle.
// A request passes the input register, then the state update and the result
//   register. One request per cycle goes through while m_tready stays high,
//   set by the combinational mode update between the two registers.
// Reset: locked, empty entry, PIN 000000, hold registers 3000 and 2000 ticks.
// Stall: when m_tready is low the result register holds and the input
//   register can still take one request; after that s_tready drops until the
//   result is taken. Nothing is lost or repeated.
module keypad_code_lock_fsm #(
    parameter int PIN_DIGITS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [3:0] key, [7:4] zero
    input  logic                             s_tuser,   // [0] func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] mode, [3] lock_open, [6:4] entered_count, [30:7] entered_digits,
    // [31] pin_write, [55:32] current_pin
    output logic [kcl_pkg::OUT_W-1:0]        m_tdata,
    input  logic                             cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kcl_pkg::HOLD_W-1:0]       cfg_data
);
    import kcl_pkg::*;

    localparam int ENTRY_W = 4 * PIN_DIGITS;
    localparam int CNT_W   = $clog2(PIN_DIGITS + 1);

    // Input register
    logic              in_valid_reg;
    logic              in_func_reg;
    logic [KEY_W-1:0]  in_key_reg;

    // Lock state
    mode_t              mode_reg, mode_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ENTRY_W-1:0] pin_reg, pin_next;
    logic [HOLD_W-1:0]  timer_reg, timer_next;
    logic [HOLD_W-1:0]  err_hold_reg;
    logic [HOLD_W-1:0]  upd_hold_reg;

    // Result register
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic               advance;
    logic               fire;
    logic               wrote;
    logic [HOLD_W:0]    timer_inc;
    logic [ENTRY_W-1:0] entry_shift;
    logic [CNT_W-1:0]   count_inc;
    logic               open_next;

    // The result register frees up when empty or taken; the input register
    // moves forward whenever the result register can load.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= s_tuser;
            in_key_reg  <= s_tdata[KEY_W-1:0];
        end
    end

    // Configuration registers; writes beyond the list fall through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_hold_reg <= ERROR_HOLD_RESET;
            upd_hold_reg <= UPDATE_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ERROR_HOLD)
            begin
                err_hold_reg <= cfg_data;
            end
            if (cfg_index == CFG_UPDATE_HOLD)
            begin
                upd_hold_reg <= cfg_data;
            end
        end
    end

    assign timer_inc   = {1'b0, timer_reg} + (HOLD_W + 1)'(1);
    assign entry_shift = (entry_reg << 4) | ENTRY_W'(in_key_reg);
    assign count_inc   = count_reg + CNT_W'(1);

    // Mode update for the request in the input register.
    always_comb
    begin
        mode_next  = mode_reg;
        entry_next = entry_reg;
        count_next = count_reg;
        pin_next   = pin_reg;
        timer_next = timer_reg;
        wrote      = 1'b0;

        if (in_func_reg == FUNC_TICK)
        begin
            // Count ticks only while a hold is running; a zero limit acts as one.
            case (mode_reg)
                ST_ERROR:
                begin
                    if (timer_inc >= {1'b0, err_hold_reg})
                    begin
                        timer_next = '0;
                        mode_next  = ST_LOCKED;
                    end
                    else
                    begin
                        timer_next = timer_inc[HOLD_W-1:0];
                    end
                end
                ST_UPDATED:
                begin
                    if (timer_inc >= {1'b0, upd_hold_reg})
                    begin
                        timer_next = '0;
                        mode_next  = ST_UNLOCKED;
                    end
                    else
                    begin
                        timer_next = timer_inc[HOLD_W-1:0];
                    end
                end
                default:
                begin
                    timer_next = timer_reg;
                end
            endcase
        end
        else if (mode_reg != ST_ERROR)
        begin
            if (in_key_reg == KEY_HASH)
            begin
                // Outside error mode, hash relocks and drops any partial entry.
                mode_next  = ST_LOCKED;
                entry_next = '0;
                count_next = '0;
            end
            else if (in_key_reg == KEY_STAR)
            begin
                if (mode_reg == ST_UNLOCKED)
                begin
                    mode_next = ST_SETPIN;
                end
            end
            else if (in_key_reg <= KEY_LAST_DIGIT &&
                     (mode_reg == ST_LOCKED || mode_reg == ST_SETPIN))
            begin
                if (count_inc == CNT_W'(PIN_DIGITS))
                begin
                    // Entry complete: check or store, then clear the entry.
                    if (mode_reg == ST_LOCKED)
                    begin
                        if (entry_shift == pin_reg)
                        begin
                            mode_next = ST_UNLOCKED;
                        end
                        else
                        begin
                            mode_next  = ST_ERROR;
                            timer_next = '0;
                        end
                    end
                    else
                    begin
                        pin_next   = entry_shift;
                        wrote      = 1'b1;
                        mode_next  = ST_UPDATED;
                        timer_next = '0;
                    end
                    entry_next = '0;
                    count_next = '0;
                end
                else
                begin
                    entry_next = entry_shift;
                    count_next = count_inc;
                end
            end
        end
    end

    assign open_next = (mode_next == ST_UNLOCKED) || (mode_next == ST_SETPIN) ||
                       (mode_next == ST_UPDATED);

    always_comb
    begin
        out_data_next = {24'(pin_next), wrote, 24'(entry_next), 3'(count_next),
                         open_next, mode_code(mode_next)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_LOCKED;
            entry_reg     <= '0;
            count_reg     <= '0;
            pin_reg       <= '0;
            timer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                mode_reg  <= mode_next;
                entry_reg <= entry_next;
                count_reg <= count_next;
                pin_reg   <= pin_next;
                timer_reg <= timer_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== hw/rtl/kcl_checker.sv =====
`include "keypad_code_lock_fsm_defines.svh"

module kcl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kcl_pkg::OUT_W-1:0]     m_tdata
);
    import kcl_pkg::*;

    logic [2:0] mode;
    logic       lock_open;
    logic [2:0] entered_count;
    logic [23:0] entered_digits;
    logic       pin_write;

    assign mode           = m_tdata[2:0];
    assign lock_open      = m_tdata[3];
    assign entered_count  = m_tdata[6:4];
    assign entered_digits = m_tdata[30:7];
    assign pin_write      = m_tdata[31];

    // Hold a stalled result.
    `KCL_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result changed while stalled")

    // Strobe the pin write only on the step that enters PIN-updated mode.
    `KCL_ASSERT_NOW(a_write_mode, m_tvalid && pin_write, mode == MODE_UPDATED,
        "pin write outside PIN-updated mode")

    // Drive the lock open exactly in the open modes.
    `KCL_ASSERT_NOW(a_open_mode, m_tvalid,
        lock_open == (mode == MODE_UNLOCKED || mode == MODE_SETPIN ||
                      mode == MODE_UPDATED),
        "lock drive disagrees with mode")

    // Error and PIN-updated modes never carry a partial entry.
    `KCL_ASSERT_NOW(a_hold_empty, m_tvalid && (mode == MODE_ERROR || mode == MODE_UPDATED),
        entered_count == 3'd0 && entered_digits == 24'd0,
        "entry not cleared during hold")

endmodule

bind keypad_code_lock_fsm kcl_checker u_kcl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
